// ===== rtl/core/drld_pkg.sv =====
// Shared types and constants for the data run list decoder.
// Used by the front parser, the token queue, the back executor and the top level.
// No dependencies.
package drld_pkg;

  // Upper bound on the run limit register; larger register values clamp to it.
  localparam int MAX_RUNS = 16;
  localparam int CNT_W = 5;

  // Depths of the token queue and of the result queue; both are powers of two.
  localparam int TOK_DEPTH = 4;
  localparam int TOK_AW = $clog2(TOK_DEPTH);
  localparam int OUT_DEPTH = 4;
  localparam int OUT_AW = $clog2(OUT_DEPTH);

  // End reasons.
  localparam logic [1:0] REASON_TERM = 2'd0;
  localparam logic [1:0] REASON_LIMIT = 2'd1;
  localparam logic [1:0] REASON_TRUNC = 2'd2;
  localparam logic [1:0] REASON_BUFEND = 2'd3;

  typedef enum logic [1:0] {
    OP_NOP,
    OP_HDR,
    OP_LEN,
    OP_OFF
  } op_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic last_byte;
  } item_t;

  typedef struct packed {
    logic run_valid;
    logic signed [63:0] run_start;
    logic [63:0] run_clusters;
    logic run_sparse;
    logic list_done;
    logic [1:0] end_reason;
    logic [CNT_W-1:0] runs_found;
  } result_t;

  // One classified byte, handed from the front parser to the back executor.
  typedef struct packed {
    op_t op;
    logic [7:0] data;
    logic [2:0] pos;
    logic use_byte;
    logic sext;
    logic had_offset;
    logic run;
    logic done;
    logic [1:0] reason;
    logic [CNT_W-1:0] runs_found;
    logic restart;
  } token_t;

endpackage

// ===== rtl/core/drld_front.sv =====
// Front parser of the data run list decoder: tracks the list phase and byte counters.
// Classifies each accepted byte into a token for the back executor. Depends on drld_pkg.
module drld_front (
  input  logic clk,
  input  logic rst,
  input  logic accept,
  input  drld_pkg::item_t item,
  input  logic max_runs_we,
  input  logic [drld_pkg::CNT_W-1:0] max_runs,
  output drld_pkg::token_t tok
);

  typedef enum logic [1:0] {
    PH_HEADER,
    PH_LENGTH,
    PH_OFFSET,
    PH_DISCARD
  } phase_t;

  phase_t phase, phase_next;
  logic [3:0] len_left, len_left_next;
  logic [3:0] off_left, off_left_next;
  logic [3:0] pos, pos_next;
  logic had_offset, had_offset_next;
  logic [drld_pkg::CNT_W-1:0] run_count, run_count_next;
  logic [drld_pkg::CNT_W-1:0] runs_cap;
  logic [drld_pkg::CNT_W-1:0] limit;
  logic [drld_pkg::CNT_W-1:0] found;
  logic [3:0] len_dec;
  logic run, done, restart;
  logic [1:0] reason;

  always_comb begin
    limit = (runs_cap > drld_pkg::CNT_W'(drld_pkg::MAX_RUNS)) ?
            drld_pkg::CNT_W'(drld_pkg::MAX_RUNS) : runs_cap;
    phase_next = phase;
    len_left_next = len_left;
    off_left_next = off_left;
    pos_next = pos;
    had_offset_next = had_offset;
    run_count_next = run_count;
    len_dec = len_left - 4'd1;
    run = 1'b0;
    done = 1'b0;
    restart = 1'b0;
    reason = drld_pkg::REASON_TERM;
    tok = '0;
    tok.op = drld_pkg::OP_NOP;
    tok.data = item.data_byte;
    tok.pos = pos[2:0];
    tok.use_byte = ~pos[3];

    unique case (phase)
      PH_HEADER: begin
        if (run_count >= limit) begin
          done = 1'b1;
          reason = drld_pkg::REASON_LIMIT;
        end else if (item.data_byte == 8'd0) begin
          done = 1'b1;
          reason = drld_pkg::REASON_TERM;
        end else if (item.last_byte) begin
          done = 1'b1;
          reason = drld_pkg::REASON_TRUNC;
        end else begin
          tok.op = drld_pkg::OP_HDR;
          len_left_next = item.data_byte[3:0];
          off_left_next = item.data_byte[7:4];
          had_offset_next = item.data_byte[7:4] != 4'd0;
          pos_next = 4'd0;
          phase_next = (item.data_byte[3:0] != 4'd0) ? PH_LENGTH : PH_OFFSET;
        end
      end
      PH_LENGTH: begin
        tok.op = drld_pkg::OP_LEN;
        pos_next = pos + 4'd1;
        len_left_next = len_dec;
        if (len_dec == 4'd0) begin
          pos_next = 4'd0;
          if (off_left == 4'd0) begin
            run = 1'b1;
          end else begin
            phase_next = PH_OFFSET;
          end
        end
        if (!run && item.last_byte) begin
          done = 1'b1;
          reason = drld_pkg::REASON_TRUNC;
        end
      end
      PH_OFFSET: begin
        tok.op = drld_pkg::OP_OFF;
        if (off_left <= 4'd1) begin
          tok.sext = (pos < 4'd7) && item.data_byte[7];
          off_left_next = 4'd0;
          pos_next = 4'd0;
          run = 1'b1;
        end else begin
          off_left_next = off_left - 4'd1;
          pos_next = pos + 4'd1;
        end
        if (!run && item.last_byte) begin
          done = 1'b1;
          reason = drld_pkg::REASON_TRUNC;
        end
      end
      PH_DISCARD: begin
        restart = item.last_byte;
      end
      default: begin
        phase_next = PH_HEADER;
      end
    endcase

    found = run ? run_count + drld_pkg::CNT_W'(1) : run_count;
    if (run) begin
      run_count_next = found;
      phase_next = PH_HEADER;
      if (found >= limit) begin
        done = 1'b1;
        reason = drld_pkg::REASON_LIMIT;
      end else if (item.last_byte) begin
        done = 1'b1;
        reason = drld_pkg::REASON_BUFEND;
      end
    end

    if (done) begin
      if (item.last_byte) begin
        restart = 1'b1;
      end else begin
        phase_next = PH_DISCARD;
      end
    end

    if (restart) begin
      phase_next = PH_HEADER;
      len_left_next = 4'd0;
      off_left_next = 4'd0;
      pos_next = 4'd0;
      had_offset_next = 1'b0;
      run_count_next = '0;
    end

    tok.had_offset = had_offset;
    tok.run = run;
    tok.done = done;
    tok.reason = reason;
    tok.runs_found = found;
    tok.restart = restart;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_HEADER;
      len_left <= 4'd0;
      off_left <= 4'd0;
      pos <= 4'd0;
      had_offset <= 1'b0;
      run_count <= '0;
      runs_cap <= drld_pkg::CNT_W'(16);
    end else begin
      if (max_runs_we) begin
        runs_cap <= max_runs;
      end
      if (accept) begin
        phase <= phase_next;
        len_left <= len_left_next;
        off_left <= off_left_next;
        pos <= pos_next;
        had_offset <= had_offset_next;
        run_count <= run_count_next;
      end
    end
  end

endmodule

// ===== rtl/core/drld_tok_queue.sv =====
// Token queue between the front parser and the back executor.
// A small register FIFO of drld_pkg::token_t entries. Depends on drld_pkg.
module drld_tok_queue (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  drld_pkg::token_t tok_in,
  output logic full,
  input  logic pop,
  output drld_pkg::token_t tok_out,
  output logic empty
);

  drld_pkg::token_t slots [drld_pkg::TOK_DEPTH];
  logic [drld_pkg::TOK_AW-1:0] wr_ptr, rd_ptr;
  logic [drld_pkg::TOK_AW:0] count;
  logic do_push, do_pop;

  assign full = count == (drld_pkg::TOK_AW + 1)'(drld_pkg::TOK_DEPTH);
  assign empty = count == '0;
  assign do_push = push && !full;
  assign do_pop = pop && !empty;
  assign tok_out = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= tok_in;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// ===== rtl/core/drld_back.sv =====
// Back executor of the data run list decoder: length and delta accumulators,
// running cluster adder and the result queue. Depends on drld_pkg.
module drld_back (
  input  logic clk,
  input  logic rst,
  input  drld_pkg::token_t tok,
  input  logic tok_empty,
  output logic tok_pop,
  output drld_pkg::result_t result,
  output logic empty,
  input  logic pop
);

  logic [63:0] len_acc, delta_acc, running;
  logic [63:0] len_new, delta_new, byte_shift, sext_mask, sum;
  drld_pkg::result_t res_new;
  drld_pkg::result_t slots [drld_pkg::OUT_DEPTH];
  logic [drld_pkg::OUT_AW-1:0] wr_ptr, rd_ptr;
  logic [drld_pkg::OUT_AW:0] count;
  logic out_full, emit, do_write, do_read;

  assign out_full = count == (drld_pkg::OUT_AW + 1)'(drld_pkg::OUT_DEPTH);
  assign empty = count == '0;
  assign tok_pop = !tok_empty && !out_full;
  assign emit = tok.run || tok.done;
  assign do_write = tok_pop && emit;
  assign do_read = pop && !empty;
  assign result = slots[rd_ptr];

  always_comb begin
    byte_shift = {56'd0, tok.data} << {tok.pos, 3'b000};
    sext_mask = tok.sext ? ({64{1'b1}} << {tok.pos + 3'd1, 3'b000}) : 64'd0;
    len_new = len_acc;
    delta_new = delta_acc;
    if (tok.op == drld_pkg::OP_LEN && tok.use_byte) begin
      len_new = len_acc | byte_shift;
    end
    if (tok.op == drld_pkg::OP_OFF) begin
      delta_new = delta_acc | (tok.use_byte ? byte_shift : 64'd0) | sext_mask;
    end
    sum = running + delta_new;

    res_new = '0;
    res_new.run_valid = tok.run;
    if (tok.run) begin
      res_new.run_start = tok.had_offset ? sum : {64{1'b1}};
      res_new.run_clusters = len_new;
      res_new.run_sparse = !tok.had_offset;
    end
    res_new.list_done = tok.done;
    res_new.end_reason = tok.reason;
    res_new.runs_found = tok.runs_found;
  end

  always_ff @(posedge clk) begin
    if (do_write) begin
      slots[wr_ptr] <= res_new;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      len_acc <= 64'd0;
      delta_acc <= 64'd0;
      running <= 64'd0;
      wr_ptr <= '0;
      rd_ptr <= '0;
      count <= '0;
    end else begin
      if (tok_pop) begin
        if (tok.op == drld_pkg::OP_HDR) begin
          len_acc <= 64'd0;
          delta_acc <= 64'd0;
        end else begin
          len_acc <= len_new;
          delta_acc <= delta_new;
        end
        if (tok.restart) begin
          running <= 64'd0;
        end else if (tok.run && tok.had_offset) begin
          running <= sum;
        end
      end
      if (do_write) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (do_read) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (do_write && !do_read) begin
        count <= count + 1'b1;
      end else if (do_read && !do_write) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// ===== rtl/core/data_run_list_decoder.sv =====
// Top level of the data run list decoder: front parser, token queue, back executor.
// Depends on drld_pkg, drld_front, drld_tok_queue and drld_back.
// Throughput: one byte beat per cycle, sustained while results are popped.
// The front classifies a byte in the cycle it is accepted and registers its token in the
// token queue; the back then pops it and writes its result into the result queue.
// Synchronous reset (rst high) empties both queues, clears the list and sets the limit to 16.
module data_run_list_decoder (
  input  logic clk,
  input  logic rst,
  input  logic push,
  output logic full,
  input  drld_pkg::item_t item,
  output logic empty,
  input  logic pop,
  output drld_pkg::result_t result,
  input  logic max_runs_we,
  input  logic [drld_pkg::CNT_W-1:0] max_runs
);

  // The front classifies every accepted beat and always produces one token, so
  // input backpressure is simply the token queue being full.
  drld_pkg::token_t front_tok;
  drld_pkg::token_t back_tok;
  logic accept;
  logic tok_empty;
  logic tok_pop;

  assign accept = push && !full;

  drld_front u_front (
    .clk(clk),
    .rst(rst),
    .accept(accept),
    .item(item),
    .max_runs_we(max_runs_we),
    .max_runs(max_runs),
    .tok(front_tok)
  );

  // The token queue decouples the parser from the result side, so a stalled
  // consumer only backs up into this queue and then into full.
  drld_tok_queue u_tok_queue (
    .clk(clk),
    .rst(rst),
    .push(accept),
    .tok_in(front_tok),
    .full(full),
    .pop(tok_pop),
    .tok_out(back_tok),
    .empty(tok_empty)
  );

  // The back executor folds bytes into the 64-bit accumulators, adds the delta
  // to the running cluster and writes finished results to its result queue.
  drld_back u_back (
    .clk(clk),
    .rst(rst),
    .tok(back_tok),
    .tok_empty(tok_empty),
    .tok_pop(tok_pop),
    .result(result),
    .empty(empty),
    .pop(pop)
  );

endmodule

// ===== test/data_run_list_checker.sv =====
`timescale 1ns / 1ps
// Checker for the data run list decoder: watches the byte and result channels,
// predicts every result from its own copy of the decoder state and compares.
// Depends on drld_pkg for the item and result types and the end reason codes.
module data_run_list_checker (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  logic full,
  input  drld_pkg::item_t item,
  input  logic empty,
  input  logic pop,
  input  drld_pkg::result_t result,
  input  logic max_runs_we,
  input  logic [drld_pkg::CNT_W-1:0] max_runs,
  output int unsigned errors,
  output int unsigned pending,
  output int unsigned beats_out,
  output int unsigned runs_seen,
  output int unsigned lists_ended
);
  import drld_pkg::*;

  typedef enum logic [1:0] {
    PARSE_HEADER,
    PARSE_LENGTH,
    PARSE_OFFSET,
    PARSE_DISCARD
  } parse_phase_t;

  parse_phase_t parse_phase;
  logic [3:0] len_count;
  logic [3:0] off_count;
  logic [3:0] field_pos;
  logic run_has_offset;
  logic [63:0] length_sum;
  logic [63:0] delta_sum;
  logic [63:0] cluster_base;
  logic [CNT_W-1:0] runs_in_list;
  logic [CNT_W-1:0] run_limit_reg;

  result_t predicted_results[$];

  function automatic void restart_list();
    parse_phase = PARSE_HEADER;
    len_count = '0;
    off_count = '0;
    field_pos = '0;
    run_has_offset = 1'b0;
    length_sum = '0;
    delta_sum = '0;
    cluster_base = '0;
    runs_in_list = '0;
  endfunction

  // Advances the decoder state by one byte; returns 1 when the byte yields a result.
  function automatic bit decode_byte(input item_t it, output result_t r);
    logic [7:0] b;
    bit last;
    int limit;
    bit run_done;
    bit list_end;
    logic [1:0] why;
    logic [63:0] start;
    b = it.data_byte;
    last = it.last_byte;
    limit = (int'(run_limit_reg) > MAX_RUNS) ? MAX_RUNS : int'(run_limit_reg);
    r = '0;
    run_done = 1'b0;
    list_end = 1'b0;
    why = REASON_TERM;
    start = '0;

    case (parse_phase)
      PARSE_HEADER: begin
        if (int'(runs_in_list) >= limit) begin
          list_end = 1'b1;
          why = REASON_LIMIT;
        end else if (b == 8'h00) begin
          list_end = 1'b1;
          why = REASON_TERM;
        end else if (last) begin
          list_end = 1'b1;
          why = REASON_TRUNC;
        end else begin
          len_count = b[3:0];
          off_count = b[7:4];
          run_has_offset = (b[7:4] != 4'd0);
          field_pos = '0;
          length_sum = '0;
          delta_sum = '0;
          parse_phase = (b[3:0] != 4'd0) ? PARSE_LENGTH : PARSE_OFFSET;
        end
      end
      PARSE_LENGTH: begin
        if (field_pos < 8) length_sum |= {56'd0, b} << (8 * field_pos);
        field_pos = field_pos + 4'd1;
        len_count = len_count - 4'd1;
        if (len_count == 4'd0) begin
          field_pos = '0;
          if (off_count == 4'd0) run_done = 1'b1;
          else parse_phase = PARSE_OFFSET;
        end
        if (!run_done && last) begin
          list_end = 1'b1;
          why = REASON_TRUNC;
        end
      end
      PARSE_OFFSET: begin
        if (field_pos < 8) delta_sum |= {56'd0, b} << (8 * field_pos);
        if (off_count <= 4'd1) begin
          // Sign extension only applies while the delta is shorter than 64 bits.
          if (field_pos < 7 && b[7]) delta_sum |= {64{1'b1}} << (8 * (field_pos + 1));
          off_count = '0;
          field_pos = '0;
          run_done = 1'b1;
        end else begin
          off_count = off_count - 4'd1;
          field_pos = field_pos + 4'd1;
        end
        if (!run_done && last) begin
          list_end = 1'b1;
          why = REASON_TRUNC;
        end
      end
      default: begin
        if (last) restart_list();
        return 1'b0;
      end
    endcase

    if (run_done) begin
      runs_in_list = runs_in_list + 1'b1;
      if (run_has_offset) begin
        cluster_base = cluster_base + delta_sum;
        start = cluster_base;
      end else begin
        start = '1;
      end
      parse_phase = PARSE_HEADER;
      if (int'(runs_in_list) >= limit) begin
        list_end = 1'b1;
        why = REASON_LIMIT;
      end else if (last) begin
        list_end = 1'b1;
        why = REASON_BUFEND;
      end
    end

    if (!run_done && !list_end) return 1'b0;

    r.run_valid = run_done;
    r.run_start = run_done ? start : '0;
    r.run_clusters = run_done ? length_sum : '0;
    r.run_sparse = run_done && !run_has_offset;
    r.list_done = list_end;
    r.end_reason = list_end ? why : REASON_TERM;
    r.runs_found = runs_in_list;

    if (list_end) begin
      if (last) restart_list();
      else parse_phase = PARSE_DISCARD;
    end
    return 1'b1;
  endfunction

  task automatic flag_error(input string msg);
    $display("%0t ERROR: %s", $time, msg);
    errors++;
  endtask

  task automatic check_field(input string name, input logic [63:0] got,
                             input logic [63:0] want);
    if (got !== want)
      flag_error($sformatf("result %0d: %s is %0h, expected %0h", beats_out, name, got, want));
  endtask

  always @(posedge clk) begin : watch
    result_t want;
    if (rst) begin
      run_limit_reg = CNT_W'(MAX_RUNS);
      restart_list();
      predicted_results.delete();
    end else begin
      if (max_runs_we) run_limit_reg = max_runs;
      if (push && !full) begin
        if (decode_byte(item, want)) predicted_results.push_back(want);
      end
      if (pop && !empty) begin
        beats_out++;
        if (predicted_results.size() == 0) begin
          flag_error($sformatf("result %0d arrived with nothing predicted", beats_out));
        end else begin
          want = predicted_results.pop_front();
          if (want.run_valid) runs_seen++;
          if (want.list_done) lists_ended++;
          check_field("run_valid", 64'(result.run_valid), 64'(want.run_valid));
          check_field("run_start", result.run_start, want.run_start);
          check_field("run_clusters", result.run_clusters, want.run_clusters);
          check_field("run_sparse", 64'(result.run_sparse), 64'(want.run_sparse));
          check_field("list_done", 64'(result.list_done), 64'(want.list_done));
          check_field("end_reason", 64'(result.end_reason), 64'(want.end_reason));
          check_field("runs_found", 64'(result.runs_found), 64'(want.runs_found));
        end
      end
    end
    pending = predicted_results.size();
  end

endmodule

// ===== test/data_run_list_decoder_test.sv =====
`timescale 1ns / 1ps
// Top of the data run list decoder testbench: clock, reset, byte stimulus,
// result draining and the verdict. Depends on drld_pkg, data_run_list_decoder
// and data_run_list_checker, which does all prediction and comparison.
module data_run_list_decoder_test;
  import drld_pkg::*;

  // Random byte beats after the directed part, and the beats in one limit setting.
  localparam int RANDOM_BEATS = 1300;
  localparam int PHASE_BEATS = 150;
  // Extra cycles after the last result so in-flight bytes without a result finish.
  localparam int SETTLE_CYCLES = 8;
  // The one long receiver hold, long enough to fill both internal queues.
  localparam int HOLD_CYCLES = 200;
  localparam int CYCLE_LIMIT = 2000000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic push = 1'b0;
  item_t item = '0;
  logic pop = 1'b0;
  logic max_runs_we = 1'b0;
  logic [CNT_W-1:0] max_runs = '0;
  logic full;
  logic empty;
  result_t result;

  int unsigned errors;
  int unsigned pending;
  int unsigned beats_out;
  int unsigned runs_seen;
  int unsigned lists_ended;

  int unsigned beats_sent = 0;
  int unsigned settings_used = 0;

  // Burst modes: while set, that side never idles.
  bit steady_in = 1'b0;
  bit steady_out = 1'b0;
  // Raised once by the stimulus; the receiver then holds off on its own.
  logic hold_request = 1'b0;

  data_run_list_decoder dut (
    .clk(clk),
    .rst(rst),
    .push(push),
    .full(full),
    .item(item),
    .empty(empty),
    .pop(pop),
    .result(result),
    .max_runs_we(max_runs_we),
    .max_runs(max_runs)
  );

  data_run_list_checker run_checker (
    .clk(clk),
    .rst(rst),
    .push(push),
    .full(full),
    .item(item),
    .empty(empty),
    .pop(pop),
    .result(result),
    .max_runs_we(max_runs_we),
    .max_runs(max_runs),
    .errors(errors),
    .pending(pending),
    .beats_out(beats_out),
    .runs_seen(runs_seen),
    .lists_ended(lists_ended)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Idle gap lengths: mostly none or short, now and then a long one.
  function automatic int pick_gap();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 50) return 0;
    if (roll < 85) return $urandom_range(1, 3);
    if (roll < 97) return $urandom_range(4, 15);
    return $urandom_range(30, 80);
  endfunction

  function automatic logic [7:0] random_byte();
    return 8'($urandom_range(0, 255));
  endfunction

  // Offers one byte beat and returns at the edge where the decoder takes it.
  // Full is read right after the edge, so it is the value the decoder saw there.
  task automatic send_beat(input logic [7:0] b, input logic is_last);
    int gap;
    gap = steady_in ? 0 : pick_gap();
    if (gap > 0) begin
      push <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    push <= 1'b1;
    // Packed order of item_t is data_byte then last_byte.
    item <= {b, is_last};
    @(posedge clk);
    while (full) @(posedge clk);
    beats_sent++;
  endtask

  // Stops offering bytes until every predicted result has been popped. The
  // count is sampled on the falling edge, clear of the checker's update, and
  // a few more cycles let any byte that yields no result leave the pipeline.
  task automatic wait_drained();
    push <= 1'b0;
    do @(negedge clk); while (pending != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Only called while the decoder is idle.
  task automatic write_limit(input int value);
    max_runs_we <= 1'b1;
    max_runs <= value[CNT_W-1:0];
    @(posedge clk);
    max_runs_we <= 1'b0;
    settings_used++;
  endtask

  // Limit settings: the extremes and the clamped values first, then random.
  function automatic int pick_limit(input int phase_no);
    case (phase_no)
      0: return 1;
      1: return MAX_RUNS;
      2: return 0;
      3: return 31;
      4: return 2;
      default: begin
        if ($urandom_range(0, 7) == 0) return $urandom_range(0, 1) ? 0 : $urandom_range(17, 31);
        return $urandom_range(1, MAX_RUNS);
      end
    endcase
  endfunction

  // One buffer: a run list built from well-formed runs with random contents,
  // closed by a terminator, by the buffer end, by a cut inside a run, or
  // replaced now and then by plain noise. The last byte is always flagged.
  task automatic send_random_list();
    logic [7:0] bytes[$];
    int runs;
    int nlen;
    int noff;
    int mode;
    int cut;
    runs = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 18) : $urandom_range(0, 5);
    for (int k = 0; k < runs; k++) begin
      // Fields longer than eight bytes are rare, since they make long lists.
      nlen = ($urandom_range(0, 19) == 0) ? $urandom_range(9, 15) : $urandom_range(0, 3);
      if ($urandom_range(0, 19) == 0) noff = $urandom_range(9, 15);
      else if ($urandom_range(0, 4) == 0) noff = 0;
      else noff = $urandom_range(1, 4);
      if (nlen == 0 && noff == 0) nlen = 1;
      bytes.push_back({noff[3:0], nlen[3:0]});
      repeat (nlen + noff) bytes.push_back(random_byte());
    end

    mode = $urandom_range(0, 19);
    if (mode < 8) begin
      // Zero header followed by a little garbage that must be thrown away.
      bytes.push_back(8'h00);
      repeat ($urandom_range(0, 3)) bytes.push_back(random_byte());
    end else if (mode < 13) begin
      // The buffer ends right after the final run.
    end else if (mode < 17) begin
      if (bytes.size() > 1) begin
        cut = $urandom_range(1, bytes.size());
        while (bytes.size() > cut) bytes.delete(bytes.size() - 1);
      end
    end else begin
      bytes.delete();
      repeat ($urandom_range(1, 12)) bytes.push_back(random_byte());
    end
    if (bytes.size() == 0) bytes.push_back(8'h00);

    for (int k = 0; k < bytes.size(); k++) send_beat(bytes[k], k == bytes.size() - 1);
  endtask

  // Receiver: pops with random stalls between result beats, and takes the one
  // long hold when asked, counting it out itself while the sender keeps going.
  initial begin : drain
    int stall;
    bit hold_taken;
    hold_taken = 1'b0;
    while (rst) @(posedge clk);
    forever begin
      if (hold_request && !hold_taken) begin
        hold_taken = 1'b1;
        pop <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else begin
        stall = steady_out ? 0 : pick_gap();
        if (stall > 0) begin
          pop <= 1'b0;
          repeat (stall) @(posedge clk);
        end
        pop <= 1'b1;
        @(posedge clk);
        while (empty) @(posedge clk);
        if ($urandom_range(0, 39) == 0) steady_out = !steady_out;
      end
    end
  end

  // Watchdog: a hung handshake ends the run as a failure.
  initial begin : watchdog
    int unsigned cycles;
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("data_run_list_decoder_test NOT OK");
    $finish;
  end

  initial begin : stimulus
    int phase_no;
    int unsigned random_start;
    int unsigned phase_start;

    repeat (8) @(posedge clk);
    rst <= 1'b0;
    write_limit(MAX_RUNS);

    // Directed part. A run with a one byte offset, then one whose two byte
    // negative delta pulls the start cluster below zero.
    send_beat(8'h11, 1'b0);
    send_beat(8'h05, 1'b0);
    send_beat(8'h10, 1'b0);
    send_beat(8'h21, 1'b0);
    send_beat(8'hFF, 1'b0);
    send_beat(8'h00, 1'b0);
    send_beat(8'h80, 1'b0);
    // A sparse run, then a zero header ends the list; the bytes after it are
    // dropped and the flagged one starts a fresh list.
    send_beat(8'h01, 1'b0);
    send_beat(8'h07, 1'b0);
    send_beat(8'h00, 1'b0);
    send_beat(8'hAA, 1'b0);
    send_beat(8'h55, 1'b1);
    // Nine length bytes, of which the ninth is ignored, and a run that ends
    // exactly on the buffer end.
    send_beat(8'h19, 1'b0);
    repeat (8) send_beat(8'hFF, 1'b0);
    send_beat(8'h01, 1'b0);
    send_beat(8'h7F, 1'b1);
    // A nonzero header on the flagged byte is a cut off run.
    send_beat(8'h31, 1'b1);

    // Two runs under the full limit, then the limit drops below the count
    // already reached, so the next header ends the list by itself.
    send_beat(8'h01, 1'b0);
    send_beat(8'h02, 1'b0);
    send_beat(8'h01, 1'b0);
    send_beat(8'h03, 1'b0);
    wait_drained();
    write_limit(1);
    send_beat(8'h11, 1'b0);
    send_beat(8'h44, 1'b1);
    // Reaching the limit on the flagged byte reports the limit, not the end.
    send_beat(8'h01, 1'b0);
    send_beat(8'h03, 1'b1);

    // Random part, one limit setting per phase. Each phase starts from an
    // idle decoder, so the sender also pauses until every result is in.
    random_start = beats_sent;
    phase_no = 0;
    while (beats_sent - random_start < RANDOM_BEATS) begin
      wait_drained();
      write_limit(pick_limit(phase_no));
      if (phase_no == 1) begin
        // Back-pressure phase: the receiver stops while bytes keep coming.
        hold_request <= 1'b1;
        steady_in = 1'b1;
      end
      phase_start = beats_sent;
      while (beats_sent - phase_start < PHASE_BEATS) begin
        if (phase_no != 1) steady_in = ($urandom_range(0, 4) == 0);
        send_random_list();
      end
      steady_in = 1'b0;
      phase_no++;
    end

    wait_drained();

    $display("Covered %0d byte beats and %0d result beats: %0d runs and %0d list ends",
             beats_sent, beats_out, runs_seen, lists_ended);
    $display("over %0d run limit settings, with one long receiver hold.", settings_used);
    if (errors == 0 && pending == 0) begin
      $display("data_run_list_decoder_test OK");
    end else begin
      $display("data_run_list_decoder_test NOT OK");
    end
    $finish;
  end

endmodule

// ===== data_run_list_decoder.f =====
rtl/core/drld_pkg.sv
rtl/core/drld_front.sv
rtl/core/drld_tok_queue.sv
rtl/core/drld_back.sv
rtl/core/data_run_list_decoder.sv
test/data_run_list_checker.sv
test/data_run_list_decoder_test.sv
